// File: src/lrupr_pkg.sv
// ----------------------------------------------------------------------------
// lrupr_pkg - shared types and constants for the LRU page replacement block
// Field widths of the stream words, reset value of the frame count register
// and the decision word passed from lookup to the frame store.
// ----------------------------------------------------------------------------
package lrupr_pkg;

  localparam int CFG_W     = 4;   // frames_in_use register
  localparam int PAGE_W    = 16;  // page field on the input word
  localparam int FIDX_W    = 3;   // frame_used field on the result word
  localparam int TOTAL_W   = 16;  // fault_total field
  localparam int S_TDATA_W = 16;
  localparam int M_TDATA_W = 40;
  localparam int M_TUSER_W = 1;

  localparam logic [CFG_W-1:0]   FRAMES_RESET = 4'd8;
  localparam logic [TOTAL_W-1:0] FAULT_MAX    = 16'hFFFF;

  // what happens to the referenced page
  typedef struct packed {
    logic hit;    // resident in a participating frame
    logic fill;   // miss, loaded into the next empty frame
    logic evict;  // miss, a resident page was replaced
  } decision_t;

endpackage

// File: src/lrupr_lookup.sv
// ----------------------------------------------------------------------------
// lrupr_lookup - hit search and victim choice
// Compares the page against every participating frame in parallel and picks
// the lowest matching frame, the next empty frame or the oldest valid frame.
// ----------------------------------------------------------------------------
module lrupr_lookup
  import lrupr_pkg::*;
#(
  parameter int MAX_FRAMES = 8,
  parameter int PAGE_BITS  = 16,
  parameter int IW         = 3,
  parameter int CW         = 4
) (
  input  logic [MAX_FRAMES-1:0]                 valid,
  input  logic [MAX_FRAMES-1:0][PAGE_BITS-1:0] pages,
  input  logic [MAX_FRAMES-1:0][IW-1:0]        ranks,
  input  logic [CW-1:0]                         filled,
  input  logic [CW-1:0]                         n_act,
  input  logic [PAGE_BITS-1:0]                  page,
  output decision_t                             dec,
  output logic [IW-1:0]                         frame,
  output logic [PAGE_BITS-1:0]                  ev_page
);

  logic [MAX_FRAMES-1:0] part;
  logic [MAX_FRAMES-1:0] match;
  logic [MAX_FRAMES-1:0] cand;
  logic [MAX_FRAMES-1:0] oldest;
  logic [IW-1:0]         f_hit;
  logic [IW-1:0]         f_vic;
  logic                  hit;
  logic                  fill;
  logic                  evict;

  always_comb begin
    for (int k = 0; k < MAX_FRAMES; k++) begin
      part[k]  = CW'(k) < n_act;
      match[k] = valid[k] && part[k] && (pages[k] == page);
      cand[k]  = valid[k] && part[k];
    end
  end

  // oldest: beats every other candidate, ties go to the lower index
  always_comb begin
    for (int k = 0; k < MAX_FRAMES; k++) begin
      oldest[k] = cand[k];
      for (int j = 0; j < MAX_FRAMES; j++) begin
        if (j < k) begin
          if (cand[j] && (ranks[j] >= ranks[k])) oldest[k] = 1'b0;
        end else if (j > k) begin
          if (cand[j] && (ranks[j] > ranks[k])) oldest[k] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    f_hit = '0;
    f_vic = '0;
    for (int k = MAX_FRAMES - 1; k >= 0; k--) begin
      if (match[k])  f_hit = IW'(k);
      if (oldest[k]) f_vic = IW'(k);
    end
  end

  always_comb begin
    hit   = |match;
    fill  = !hit && (filled < n_act);
    evict = !hit && !fill && valid[f_vic];
    dec   = '{hit: hit, fill: fill, evict: evict};
    if (hit) begin
      frame = f_hit;
    end else if (fill) begin
      frame = filled[IW-1:0];
    end else begin
      frame = f_vic;
    end
    ev_page = evict ? pages[f_vic] : '0;
  end

endmodule

// File: src/lrupr_frames.sv
// ----------------------------------------------------------------------------
// lrupr_frames - frame store and recency ranks
// Holds page, valid mark and rank per frame plus the fill count, and applies
// the decision of one reference per cycle while upd is high.
// ----------------------------------------------------------------------------
module lrupr_frames
  import lrupr_pkg::*;
#(
  parameter int MAX_FRAMES = 8,
  parameter int PAGE_BITS  = 16,
  parameter int IW         = 3,
  parameter int CW         = 4
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  upd,
  input  decision_t                             dec,
  input  logic [IW-1:0]                         frame,
  input  logic [PAGE_BITS-1:0]                  page,
  output logic [MAX_FRAMES-1:0]                 valid,
  output logic [MAX_FRAMES-1:0][PAGE_BITS-1:0] pages,
  output logic [MAX_FRAMES-1:0][IW-1:0]        ranks,
  output logic [CW-1:0]                         filled
);

  logic aged;  // frame was resident, so only newer frames age

  assign aged = dec.hit || dec.evict;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      ranks  <= '0;
      filled <= '0;
    end else if (upd) begin
      for (int k = 0; k < MAX_FRAMES; k++) begin
        if ((IW'(k) != frame) && valid[k] && (!aged || (ranks[k] < ranks[frame]))) begin
          ranks[k] <= ranks[k] + IW'(1);
        end
      end
      ranks[frame] <= '0;
      valid[frame] <= 1'b1;
      if (dec.fill) filled <= filled + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (upd && !dec.hit) pages[frame] <= page;
  end

endmodule

// File: src/lru_page_replacement.sv
// ----------------------------------------------------------------------------
// lru_page_replacement - LRU page replacement over a small frame set
// One page reference per input word, one result word per reference.
// ----------------------------------------------------------------------------
// Input stream s_*: s_tdata[15:0] is the referenced page.
// Result stream m_*: m_tuser[0] is the fault flag (1 = miss, page loaded);
// m_tdata carries frame_used, evicted_valid, evicted_page and fault_total.
// cfg_we/cfg_wdata write frames_in_use (0 acts as 1, above MAX_FRAMES acts
// as MAX_FRAMES); write it only while no reference is in flight.
// A word accepted on s_* passes the input register, then the result
// register, before it is on m_*. Throughput: one reference per cycle
// while m_tready is high; lookup, victim choice and rank update of all
// frames happen combinationally between the input and result registers,
// so consecutive words see each other's state changes without stalls.
// When the receiver stalls, the result word holds and the input register
// still takes one more word; after that s_tready drops until m_tready.
// Reset empties all frames, clears ranks, fill count and fault count, and
// sets frames_in_use to 8. Page contents are left unreset.
// ----------------------------------------------------------------------------
module lru_page_replacement
  import lrupr_pkg::*;
#(
  parameter int MAX_FRAMES = 8,
  parameter int PAGE_BITS  = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_W-1:0]     cfg_wdata,  // frames_in_use
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,    // [15:0] page
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // [2:0] frame_used, [3] evicted_valid, [19:4] evicted_page,
  // [35:20] fault_total, [39:36] zero
  output logic [M_TDATA_W-1:0] m_tdata,
  output logic [M_TUSER_W-1:0] m_tuser     // [0] fault
);

  localparam int IW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CW = $clog2(MAX_FRAMES + 1);

  logic [CFG_W-1:0]                      frames_cfg;
  logic [CW-1:0]                         n_act;
  logic                                  in_valid;
  logic [PAGE_BITS-1:0]                  in_page;
  logic [PAGE_BITS+PAGE_W-1:0]           page_wide;
  logic                                  advance;
  decision_t                             dec;
  logic [IW-1:0]                         frame;
  logic [PAGE_BITS-1:0]                  ev_page;
  logic [MAX_FRAMES-1:0]                 valid;
  logic [MAX_FRAMES-1:0][PAGE_BITS-1:0] pages;
  logic [MAX_FRAMES-1:0][IW-1:0]        ranks;
  logic [CW-1:0]                         filled;
  logic [TOTAL_W-1:0]                    fault_count;
  logic [TOTAL_W-1:0]                    fault_count_next;
  logic [IW+FIDX_W-1:0]                  frame_wide;
  logic [PAGE_BITS+PAGE_W-1:0]           ev_wide;
  logic                                  res_fault;
  logic [FIDX_W-1:0]                     res_frame;
  logic                                  res_ev_valid;
  logic [PAGE_W-1:0]                     res_ev_page;
  logic [TOTAL_W-1:0]                    res_total;

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_cfg <= FRAMES_RESET;
    end else if (cfg_we) begin
      frames_cfg <= cfg_wdata;
    end
  end

  always_comb begin
    if (32'(frames_cfg) > MAX_FRAMES) begin
      n_act = CW'(MAX_FRAMES);
    end else if (frames_cfg == '0) begin
      n_act = CW'(1);
    end else begin
      n_act = CW'(frames_cfg);
    end
  end

  assign advance   = in_valid && (!m_tvalid || m_tready);
  assign s_tready  = !in_valid || advance;
  assign page_wide = {{PAGE_BITS{1'b0}}, s_tdata[PAGE_W-1:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) in_page <= page_wide[PAGE_BITS-1:0];
  end

  lrupr_lookup #(
    .MAX_FRAMES(MAX_FRAMES),
    .PAGE_BITS (PAGE_BITS),
    .IW        (IW),
    .CW        (CW)
  ) u_lookup (
    .valid  (valid),
    .pages  (pages),
    .ranks  (ranks),
    .filled (filled),
    .n_act  (n_act),
    .page   (in_page),
    .dec    (dec),
    .frame  (frame),
    .ev_page(ev_page)
  );

  lrupr_frames #(
    .MAX_FRAMES(MAX_FRAMES),
    .PAGE_BITS (PAGE_BITS),
    .IW        (IW),
    .CW        (CW)
  ) u_frames (
    .clk   (clk),
    .rst   (rst),
    .upd   (advance),
    .dec   (dec),
    .frame (frame),
    .page  (in_page),
    .valid (valid),
    .pages (pages),
    .ranks (ranks),
    .filled(filled)
  );

  // saturating fault count, includes the current miss
  always_comb begin
    fault_count_next = fault_count;
    if (!dec.hit && (fault_count != FAULT_MAX)) fault_count_next = fault_count + TOTAL_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fault_count <= '0;
    end else if (advance) begin
      fault_count <= fault_count_next;
    end
  end

  assign frame_wide = {{FIDX_W{1'b0}}, frame};
  assign ev_wide    = {{PAGE_W{1'b0}}, ev_page};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_fault    <= !dec.hit;
      res_frame    <= frame_wide[FIDX_W-1:0];
      res_ev_valid <= dec.evict;
      res_ev_page  <= ev_wide[PAGE_W-1:0];
      res_total    <= fault_count_next;
    end
  end

  assign m_tdata = {4'b0000, res_total, res_ev_page, res_ev_valid, res_frame};
  assign m_tuser = res_fault;

endmodule

// File: src/lrupr_checker.sv
// ----------------------------------------------------------------------------
// lrupr_checker - port-level checks for lru_page_replacement
// Watches the result stream for holding under stall and for consistent
// hit, eviction and fault count fields.
// ----------------------------------------------------------------------------
module lrupr_checker
  import lrupr_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata,
  input logic [M_TUSER_W-1:0] m_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result word changed while stalled");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> !m_tdata[3])
    else $error("eviction reported on a hit");

  a_evict_page_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[3] |-> m_tdata[19:4] == 16'h0000)
    else $error("evicted page non-zero with no eviction");

  a_fault_counted: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[35:20] != 16'h0000)
    else $error("fault word with zero fault total");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid straight after reset");

endmodule

bind lru_page_replacement lrupr_checker u_lrupr_checker (
  .clk     (clk),
  .rst     (rst),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser)
);

// File: bench/tb_lru_page_replacement.sv
// ----------------------------------------------------------------------------
// tb_lru_page_replacement - self-checking bench for the LRU page replacement
// Page references go in on the s_* stream and the bench keeps its own model
// of frames, ranks, fill count and fault count. Every result word on m_* is
// checked field by field against the oldest pending prediction. Covers
// directed corner cases, random working sets under idling and stalls, and a
// long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_lru_page_replacement;
  import lrupr_pkg::*;

  localparam int NUM_FRAMES = 8;

  typedef struct packed {
    logic               fault;
    logic [FIDX_W-1:0]  frame;
    logic               ev_valid;
    logic [PAGE_W-1:0]  ev_page;
    logic [TOTAL_W-1:0] total;
  } page_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic [M_TUSER_W-1:0] m_tuser;

  lru_page_replacement dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always #2 clk = ~clk;

  // bench copy of the frame store
  logic [PAGE_W-1:0]  frame_page [NUM_FRAMES];
  logic               frame_ok   [NUM_FRAMES];
  logic [2:0]         frame_rank [NUM_FRAMES];
  logic [CFG_W-1:0]   frames_filled;
  logic [TOTAL_W-1:0] fault_count;
  logic [CFG_W-1:0]   frames_cfg;

  page_result_t pending_results[$];
  int           mismatch_count = 0;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  int           hold_cycles = 0;

  initial begin
    for (int k = 0; k < NUM_FRAMES; k++) begin
      frame_page[k] = '0;
      frame_ok[k]   = 1'b0;
      frame_rank[k] = '0;
    end
    frames_filled = '0;
    fault_count   = '0;
    frames_cfg    = FRAMES_RESET;
  end

  // frame f becomes newest; valid frames newer than it age by one
  function automatic void promote_frame(int f, bit was_valid);
    int r;
    r = was_valid ? int'(frame_rank[f]) : NUM_FRAMES;
    for (int k = 0; k < NUM_FRAMES; k++)
      if (k != f && frame_ok[k] && int'(frame_rank[k]) < r)
        frame_rank[k] = frame_rank[k] + 3'd1;
    frame_rank[f] = '0;
  endfunction

  function automatic page_result_t lookup_and_replace(logic [PAGE_W-1:0] pg);
    int           n;
    int           f;
    int           oldest;
    bit           hit;
    bit           found;
    page_result_t res;
    n = int'(frames_cfg);
    if (n < 1) n = 1;
    if (n > NUM_FRAMES) n = NUM_FRAMES;
    f   = 0;
    hit = 1'b0;
    res = '0;
    for (int k = 0; k < n; k++)
      if (!hit && frame_ok[k] && frame_page[k] == pg) begin
        f   = k;
        hit = 1'b1;
      end
    if (hit) begin
      promote_frame(f, 1'b1);
    end else begin
      if (int'(frames_filled) < n) begin
        f = int'(frames_filled);
        promote_frame(f, 1'b0);
        frame_ok[f]   = 1'b1;
        frame_page[f] = pg;
        frames_filled = frames_filled + 1'b1;
      end else begin
        found  = 1'b0;
        oldest = 0;
        f      = 0;
        for (int k = 0; k < n; k++)
          if (frame_ok[k] && (!found || int'(frame_rank[k]) > oldest)) begin
            oldest = int'(frame_rank[k]);
            f      = k;
            found  = 1'b1;
          end
        res.ev_valid = frame_ok[f];
        res.ev_page  = frame_ok[f] ? frame_page[f] : '0;
        promote_frame(f, frame_ok[f]);
        frame_ok[f]   = 1'b1;
        frame_page[f] = pg;
      end
      if (fault_count != FAULT_MAX) fault_count = fault_count + 1'b1;
    end
    res.fault = !hit;
    res.frame = f[FIDX_W-1:0];
    res.total = fault_count;
    return res;
  endfunction

  // receiver: random stalls, plus a counted hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        hold_cycles = hold_cycles - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic check_field(string what, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    page_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result word with nothing pending, expected none, actual %0h/%0h",
                 $time, m_tuser, m_tdata);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("fault", 16'(want.fault), 16'(m_tuser[0]));
        check_field("frame_used", 16'(want.frame), 16'(m_tdata[2:0]));
        check_field("evicted_valid", 16'(want.ev_valid), 16'(m_tdata[3]));
        check_field("evicted_page", want.ev_page, m_tdata[19:4]);
        check_field("fault_total", want.total, m_tdata[35:20]);
      end
    end
  end

  task automatic send_page(logic [PAGE_W-1:0] pg);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= pg;
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(lookup_and_replace(pg));
  endtask

  task automatic stop_stream();
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  // wait for every pending word, then the pipeline depth and a margin
  task automatic drain();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_frames(logic [CFG_W-1:0] v);
    stop_stream();
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we     <= 1'b0;
    frames_cfg = v;
  endtask

  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // two frames, fill then evict the older one
    set_frames(4'd2);
    send_page(16'h0000);
    send_page(16'hFFFF);
    send_page(16'h0000);
    send_page(16'h1234);
    // count raised: filling resumes where it stopped
    set_frames(4'd5);
    send_page(16'hFFFF);
    send_page(16'h5555);
    send_page(16'hAAAA);
    send_page(16'h1234);
    send_page(16'h7777);
    // zero acts as a single frame; frame 0 replaced on every miss
    set_frames(4'd0);
    send_page(16'h0001);
    send_page(16'h0001);
    send_page(16'h0002);
    // above the maximum acts as eight
    set_frames(4'd15);
    send_page(16'h0003);
    send_page(16'h0004);
    send_page(16'h0005);
    send_page(16'h8000);
    // count lowered: upper frames hidden, page reloaded low (duplicate)
    set_frames(4'd3);
    send_page(16'h0005);
    send_page(16'h0004);
    set_frames(4'd1);
    send_page(16'h0005);
    // back to eight: lowest matching frame wins
    set_frames(4'd8);
    send_page(16'h0005);
    send_page(16'h0004);
    send_page(16'hFFFF);
  endtask

  task automatic test_random_phase(int idle_pct, int stall_pct, logic [CFG_W-1:0] frames,
                                   int count);
    logic [PAGE_W-1:0] pool [12];
    int                pool_size;
    set_frames(frames);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    pool_size = (frames == 0 ? 1 : (frames > 8 ? 8 : int'(frames))) + $urandom_range(0, 3);
    for (int k = 0; k < 12; k++) pool[k] = PAGE_W'($urandom);
    for (int i = 0; i < count; i++) begin
      // mostly a working set with reuse, the rest arbitrary pages
      if ($urandom_range(99) < 75) send_page(pool[$urandom_range(0, pool_size - 1)]);
      else send_page(PAGE_W'($urandom));
    end
  endtask

  task automatic test_backpressure();
    set_frames(4'd4);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    @(posedge clk);
    hold_cycles = 300;
    for (int i = 0; i < 40; i++) send_page(PAGE_W'($urandom_range(0, 7)));
    // sender pauses until all results are back
    stop_stream();
    drain();
    recv_stall_pct = 30;
    for (int i = 0; i < 20; i++) send_page(PAGE_W'($urandom_range(0, 7)));
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_phase(0, 0, 4'd8, 100);
    test_random_phase(49, 0, 4'd1, 140);
    test_random_phase(0, 49, 4'($urandom_range(1, 8)), 140);
    test_random_phase(18, 18, 4'($urandom_range(0, 15)), 140);
    test_random_phase(0, 0, 4'($urandom_range(2, 7)), 100);
    test_backpressure();
    stop_stream();
    drain();
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule
